/* rtl/core/rre_pkg.sv */
package rre_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int COORD_W = 20;
  localparam int DIM_W   = 10;
  localparam int CHAR_W  = 8;
  localparam int CELL_W  = 9;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 2;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_BACKGROUND    = 2'd2;

  localparam logic [DIM_W-1:0]  RESET_DIM    = 10'd1;
  localparam logic [CHAR_W-1:0] RESET_BG     = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_READ,
    ST_RESULT
  } state_t;

  // bound precompute sequence on the shared adder
  typedef enum logic [2:0] {
    STEP_X1,
    STEP_Y1,
    STEP_XL,
    STEP_YL,
    STEP_XR,
    STEP_YR
  } step_t;

endpackage

/* rtl/core/rre_if.sv */
interface rre_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rre_pkg::IDX_W-1:0]   index;
  logic [rre_pkg::DIM_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface rre_req_if;
  logic                               valid;
  logic                               ready;
  logic [rre_pkg::KIND_W-1:0]         kind;
  logic                               rect_filled;
  logic signed [rre_pkg::COORD_W-1:0] rect_x;
  logic signed [rre_pkg::COORD_W-1:0] rect_y;
  logic signed [rre_pkg::COORD_W-1:0] rect_w;
  logic signed [rre_pkg::COORD_W-1:0] rect_h;
  logic [rre_pkg::CHAR_W-1:0]         paint_char;
  logic [rre_pkg::CELL_W-1:0]         read_row;
  logic [rre_pkg::CELL_W-1:0]         read_col;

  modport source(output valid, kind, rect_filled, rect_x, rect_y, rect_w, rect_h,
                 paint_char, read_row, read_col, input ready);
  modport sink(input valid, kind, rect_filled, rect_x, rect_y, rect_w, rect_h,
               paint_char, read_row, read_col, output ready);
endinterface

interface rre_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [rre_pkg::CHAR_W-1:0] cell_char;

  modport source(output valid, status, cell_char, input ready);
  modport sink(input valid, status, cell_char, output ready);
endinterface

/* rtl/core/rre_canvas.sv */
module rre_canvas #(
  parameter int DEPTH = rre_pkg::MAX_WIDTH_DEF * rre_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rre_pkg::CHAR_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [rre_pkg::CHAR_W-1:0] rdata
);

  logic [rre_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rectangle_raster_engine.sv */
// Clear: one canvas write per cycle over the cells in use.
// Draw: six bound sums on one shared adder, then the sweep.
// Rejected draw, unused kind: straight to result. Read: via the registered port.
// One item at a time; the next item is taken while a result waits at the output.
// Synchronous reset clears control and config registers, not the canvas.
module rectangle_raster_engine #(
  parameter int MAX_WIDTH  = rre_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rre_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = rre_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  rre_cfg_if.sink     cfg,
  rre_req_if.sink     req,
  rre_rsp_if.source   rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CLW   = $clog2(MAX_WIDTH + 1);
  localparam int RLW   = $clog2(MAX_HEIGHT + 1);
  localparam int MAXB  = (CLW > RLW) ? CLW : RLW;
  localparam int PW    = (MAXB + FRAC_BITS + 1 > rre_pkg::COORD_W + 3) ?
                         MAXB + FRAC_BITS + 1 : rre_pkg::COORD_W + 3;
  localparam logic signed [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] NEG_ONE = -ONE;

  rre_pkg::state_t state, state_next;
  rre_pkg::step_t  step;

  logic [rre_pkg::DIM_W-1:0]  canvas_width;
  logic [rre_pkg::DIM_W-1:0]  canvas_height;
  logic [rre_pkg::CHAR_W-1:0] background_char;
  logic [CLW-1:0]             cols_lim;
  logic [RLW-1:0]             rows_lim;

  logic [rre_pkg::KIND_W-1:0] kind_q;
  logic                       filled_q;
  logic [rre_pkg::CHAR_W-1:0] paint_q;
  logic                       reject_q;
  logic signed [PW-1:0]       x0, y0, w_q, h_q, x1, y1, xl, yl, xr, yr;
  logic signed [PW-1:0]       opa, opb, sum;
  logic signed [PW-1:0]       px, py;
  logic [CB-1:0]              col;
  logic [RB-1:0]              row;
  logic [AW-1:0]              row_base;
  logic                       col_last, row_last;
  logic                       draw_bad;
  logic                       in_col, in_row, near_edge;

  logic [AW-1:0]              rd_addr;
  logic                       rd_ok;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr;
  logic [rre_pkg::CHAR_W-1:0] mem_wdata, rd_data;

  logic                       rsp_valid;
  logic                       rsp_status;
  logic [rre_pkg::CHAR_W-1:0] rsp_char;
  logic                       rsp_load;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= rre_pkg::RESET_DIM;
      canvas_height   <= rre_pkg::RESET_DIM;
      background_char <= rre_pkg::RESET_BG;
    end else if (cfg.valid) begin
      case (cfg.index)
        rre_pkg::REG_CANVAS_WIDTH:  canvas_width    <= cfg.data;
        rre_pkg::REG_CANVAS_HEIGHT: canvas_height   <= cfg.data;
        rre_pkg::REG_BACKGROUND:    background_char <= cfg.data[rre_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (canvas_width == '0) begin
      cols_lim = CLW'(1);
    end else if (int'(canvas_width) > MAX_WIDTH) begin
      cols_lim = CLW'(MAX_WIDTH);
    end else begin
      cols_lim = CLW'(canvas_width);
    end
    if (canvas_height == '0) begin
      rows_lim = RLW'(1);
    end else if (int'(canvas_height) > MAX_HEIGHT) begin
      rows_lim = RLW'(MAX_HEIGHT);
    end else begin
      rows_lim = RLW'(canvas_height);
    end
  end

  // shared adder
  always_comb begin
    case (step)
      rre_pkg::STEP_X1: begin opa = x0; opb = w_q;     end
      rre_pkg::STEP_Y1: begin opa = y0; opb = h_q;     end
      rre_pkg::STEP_XL: begin opa = x0; opb = ONE;     end
      rre_pkg::STEP_YL: begin opa = y0; opb = ONE;     end
      rre_pkg::STEP_XR: begin opa = x1; opb = NEG_ONE; end
      rre_pkg::STEP_YR: begin opa = y1; opb = NEG_ONE; end
      default:          begin opa = x0; opb = w_q;     end
    endcase
  end

  assign sum = opa + opb;

  assign draw_bad = req.rect_w[rre_pkg::COORD_W-1] || (req.rect_w == '0) ||
                    req.rect_h[rre_pkg::COORD_W-1] || (req.rect_h == '0) ||
                    (req.paint_char == '0) || (req.paint_char == rre_pkg::NEWLINE_CHAR);

  // sweep
  assign col_last  = (CLW'(col) + CLW'(1)) == cols_lim;
  assign row_last  = (RLW'(row) + RLW'(1)) == rows_lim;
  assign px        = $signed(PW'(col)) <<< FRAC_BITS;
  assign py        = $signed(PW'(row)) <<< FRAC_BITS;
  assign in_col    = (px >= x0) && (px <= x1);
  assign in_row    = (py >= y0) && (py <= y1);
  assign near_edge = (px < xl) || (px > xr) || (py < yl) || (py > yr);

  assign mem_we    = (state == rre_pkg::ST_SWEEP) &&
                     ((kind_q == rre_pkg::KIND_CLEAR) ||
                      (in_col && in_row && (near_edge || filled_q)));
  assign mem_wdata = (kind_q == rre_pkg::KIND_CLEAR) ? background_char : paint_q;
  assign mem_waddr = row_base + AW'(col);
  assign mem_re    = (state == rre_pkg::ST_READ) && rd_ok;

  rre_canvas #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_canvas (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // sequencer
  assign req.ready = (state == rre_pkg::ST_IDLE);
  assign rsp_load  = (state == rre_pkg::ST_RESULT) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rre_pkg::ST_IDLE: begin
        if (req.valid) begin
          case (req.kind)
            rre_pkg::KIND_CLEAR: state_next = rre_pkg::ST_SWEEP;
            rre_pkg::KIND_DRAW:  state_next = draw_bad ? rre_pkg::ST_RESULT
                                                       : rre_pkg::ST_SETUP;
            rre_pkg::KIND_READ:  state_next = rre_pkg::ST_READ;
            default:             state_next = rre_pkg::ST_RESULT;
          endcase
        end
      end
      rre_pkg::ST_SETUP: begin
        if (step == rre_pkg::STEP_YR) begin
          state_next = rre_pkg::ST_SWEEP;
        end
      end
      rre_pkg::ST_SWEEP: begin
        if (col_last && row_last) begin
          state_next = rre_pkg::ST_RESULT;
        end
      end
      rre_pkg::ST_READ:   state_next = rre_pkg::ST_RESULT;
      rre_pkg::ST_RESULT: begin
        if (rsp_load) begin
          state_next = rre_pkg::ST_IDLE;
        end
      end
      default: state_next = rre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= rre_pkg::STEP_X1;
      kind_q   <= rre_pkg::KIND_CLEAR;
      reject_q <= 1'b0;
      rd_ok    <= 1'b0;
    end else begin
      case (state)
        rre_pkg::ST_IDLE: begin
          if (req.valid) begin
            kind_q   <= req.kind;
            filled_q <= req.rect_filled;
            paint_q  <= req.paint_char;
            x0       <= PW'(req.rect_x);
            y0       <= PW'(req.rect_y);
            w_q      <= PW'(req.rect_w);
            h_q      <= PW'(req.rect_h);
            step     <= rre_pkg::STEP_X1;
            col      <= '0;
            row      <= '0;
            row_base <= '0;
            reject_q <= (req.kind == rre_pkg::KIND_DRAW) && draw_bad;
            rd_ok    <= (req.kind == rre_pkg::KIND_READ) &&
                        (int'(req.read_row) < int'(rows_lim)) &&
                        (int'(req.read_col) < int'(cols_lim));
            rd_addr  <= AW'(int'(req.read_row) * MAX_WIDTH + int'(req.read_col));
          end
        end
        rre_pkg::ST_SETUP: begin
          case (step)
            rre_pkg::STEP_X1: begin x1 <= sum; step <= rre_pkg::STEP_Y1; end
            rre_pkg::STEP_Y1: begin y1 <= sum; step <= rre_pkg::STEP_XL; end
            rre_pkg::STEP_XL: begin xl <= sum; step <= rre_pkg::STEP_YL; end
            rre_pkg::STEP_YL: begin yl <= sum; step <= rre_pkg::STEP_XR; end
            rre_pkg::STEP_XR: begin xr <= sum; step <= rre_pkg::STEP_YR; end
            rre_pkg::STEP_YR: begin yr <= sum; step <= rre_pkg::STEP_X1; end
            default:          step <= rre_pkg::STEP_X1;
          endcase
        end
        rre_pkg::ST_SWEEP: begin
          if (col_last) begin
            col      <= '0;
            row      <= row + RB'(1);
            row_base <= row_base + AW'(MAX_WIDTH);
          end else begin
            col <= col + CB'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status <= reject_q;
      rsp_char   <= rd_ok ? rd_data : '0;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.cell_char = rsp_char;

  a_sweep_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state == rre_pkg::ST_SWEEP |-> (CLW'(col) < cols_lim) && (RLW'(row) < rows_lim))
    else $error("sweep counter beyond canvas in use");

  a_reject_from_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && rsp_status |-> kind_q == rre_pkg::KIND_DRAW)
    else $error("reject status on a non-draw item");

  a_no_paint_when_rejected: assert property (@(posedge clk) disable iff (rst)
    state == rre_pkg::ST_SWEEP |-> !reject_q)
    else $error("sweep started for a rejected draw");

  a_char_only_on_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && (rsp_char != '0) |-> (kind_q == rre_pkg::KIND_READ) && rd_ok)
    else $error("cell char returned for a non-read item");

  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    (state == rre_pkg::ST_RESULT) && rsp_valid && !rsp.ready |=>
      state == rre_pkg::ST_RESULT)
    else $error("pending result overwritten");

endmodule

/* bench/tb_rectangle_raster_engine.sv */
`timescale 1ns / 100ps

module tb_rectangle_raster_engine;

  localparam int ONE          = 1 << rre_pkg::FRAC_BITS_DEF;
  localparam int CANVAS_CELLS = rre_pkg::MAX_WIDTH_DEF * rre_pkg::MAX_HEIGHT_DEF;

  localparam logic [rre_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [rre_pkg::IDX_W-1:0]  REG_UNUSED  = 2'd3;

  typedef struct {
    logic [rre_pkg::KIND_W-1:0]         kind;
    logic                               rect_filled;
    logic signed [rre_pkg::COORD_W-1:0] rect_x;
    logic signed [rre_pkg::COORD_W-1:0] rect_y;
    logic signed [rre_pkg::COORD_W-1:0] rect_w;
    logic signed [rre_pkg::COORD_W-1:0] rect_h;
    logic [rre_pkg::CHAR_W-1:0]         paint_char;
    logic [rre_pkg::CELL_W-1:0]         read_row;
    logic [rre_pkg::CELL_W-1:0]         read_col;
  } raster_req_t;

  typedef struct packed {
    logic                       status;
    logic [rre_pkg::CHAR_W-1:0] cell_char;
  } raster_rsp_t;

  class canvas_checker;
    logic [rre_pkg::CHAR_W-1:0] cells [CANVAS_CELLS];
    logic [rre_pkg::DIM_W-1:0]  width_reg;
    logic [rre_pkg::DIM_W-1:0]  height_reg;
    logic [rre_pkg::CHAR_W-1:0] bg_reg;
    raster_rsp_t                owed_replies[$];
    int                         errors;

    function new();
      width_reg  = rre_pkg::RESET_DIM;
      height_reg = rre_pkg::RESET_DIM;
      bg_reg     = rre_pkg::RESET_BG;
      errors     = 0;
    endfunction

    function int cols_in_use();
      if (width_reg == 0) return 1;
      if (width_reg > rre_pkg::MAX_WIDTH_DEF) return rre_pkg::MAX_WIDTH_DEF;
      return int'(width_reg);
    endfunction

    function int rows_in_use();
      if (height_reg == 0) return 1;
      if (height_reg > rre_pkg::MAX_HEIGHT_DEF) return rre_pkg::MAX_HEIGHT_DEF;
      return int'(height_reg);
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction

    function void write_reg(logic [rre_pkg::IDX_W-1:0] idx, logic [rre_pkg::DIM_W-1:0] value);
      case (idx)
        rre_pkg::REG_CANVAS_WIDTH:  width_reg = value;
        rre_pkg::REG_CANVAS_HEIGHT: height_reg = value;
        rre_pkg::REG_BACKGROUND:    bg_reg = value[rre_pkg::CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_request(raster_req_t it);
      raster_rsp_t rsp;
      int cols;
      int rows;
      longint x0, y0, x1, y1, px, py;
      bit on_edge;
      cols = cols_in_use();
      rows = rows_in_use();
      rsp  = '0;
      case (it.kind)
        rre_pkg::KIND_CLEAR: begin
          for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
              cells[r * rre_pkg::MAX_WIDTH_DEF + c] = bg_reg;
        end
        rre_pkg::KIND_DRAW: begin
          x0 = it.rect_x;
          y0 = it.rect_y;
          x1 = x0 + longint'(it.rect_w);
          y1 = y0 + longint'(it.rect_h);
          if (it.rect_w <= 0 || it.rect_h <= 0 || it.paint_char == 0 ||
              it.paint_char == rre_pkg::NEWLINE_CHAR) begin
            rsp.status = 1'b1;
          end else begin
            for (int r = 0; r < rows; r++) begin
              py = longint'(r) * ONE;
              if (py < y0 || py > y1) continue;
              for (int c = 0; c < cols; c++) begin
                px = longint'(c) * ONE;
                if (px < x0 || px > x1) continue;
                on_edge = (px - x0 < ONE) || (x1 - px < ONE) ||
                          (py - y0 < ONE) || (y1 - py < ONE);
                if (on_edge || it.rect_filled)
                  cells[r * rre_pkg::MAX_WIDTH_DEF + c] = it.paint_char;
              end
            end
          end
        end
        rre_pkg::KIND_READ: begin
          if (it.read_row < rows && it.read_col < cols)
            rsp.cell_char = cells[it.read_row * rre_pkg::MAX_WIDTH_DEF + it.read_col];
        end
        default: ;
      endcase
      owed_replies.push_back(rsp);
    endfunction

    function void check_reply(logic status, logic [rre_pkg::CHAR_W-1:0] cell_char);
      raster_rsp_t want;
      if (owed_replies.size() == 0) begin
        $error("reply with no item outstanding: status %0d cell_char %0d",
               status, cell_char);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (cell_char !== want.cell_char) begin
        $error("cell_char: expected %0d, got %0d", want.cell_char, cell_char);
        errors++;
      end
    endfunction

    function void report_leftovers();
      if (owed_replies.size() != 0) begin
        $error("%0d replies never arrived", owed_replies.size());
        errors += owed_replies.size();
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rre_cfg_if cfg_bus();
  rre_req_if req_bus();
  rre_rsp_if rsp_bus();

  rectangle_raster_engine u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #1 clk = ~clk;

  canvas_checker sb;
  raster_req_t   plan[$];
  int            burst_left = 0;
  int unsigned   ready_tick = 0;

  // reply stall pattern: free, sparse random, periodic, heavy random
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      case (ready_tick[9:8])
        2'd0: rsp_bus.ready <= 1'b1;
        2'd1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
        2'd2: rsp_bus.ready <= (ready_tick[2:0] != 3'd5);
        default: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
      sb.check_reply(rsp_bus.status, rsp_bus.cell_char);
  end

  task automatic drain_replies();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [rre_pkg::IDX_W-1:0] idx,
                                input logic [rre_pkg::DIM_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.write_reg(idx, value);
  endtask

  task automatic set_canvas(input int w, input int h, input int bg);
    logic [rre_pkg::DIM_W-1:0] bg_word;
    drain_replies();
    bg_word = rre_pkg::DIM_W'($urandom);
    bg_word[rre_pkg::CHAR_W-1:0] = bg[rre_pkg::CHAR_W-1:0];
    write_register(rre_pkg::REG_CANVAS_WIDTH, w[rre_pkg::DIM_W-1:0]);
    write_register(rre_pkg::REG_CANVAS_HEIGHT, h[rre_pkg::DIM_W-1:0]);
    write_register(rre_pkg::REG_BACKGROUND, bg_word);
    write_register(REG_UNUSED, rre_pkg::DIM_W'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_request(input raster_req_t it, input bit last);
    int gap;
    req_bus.valid       <= 1'b1;
    req_bus.kind        <= it.kind;
    req_bus.rect_filled <= it.rect_filled;
    req_bus.rect_x      <= it.rect_x;
    req_bus.rect_y      <= it.rect_y;
    req_bus.rect_w      <= it.rect_w;
    req_bus.rect_h      <= it.rect_h;
    req_bus.paint_char  <= it.paint_char;
    req_bus.read_row    <= it.read_row;
    req_bus.read_col    <= it.read_col;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    sb.take_request(it);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (last || gap != 0) req_bus.valid <= 1'b0;
    repeat (gap) @(posedge clk);
    if (gap != 0 && $urandom_range(0, 11) == 0) drain_replies();
  endtask

  task automatic flush_plan();
    foreach (plan[i]) send_request(plan[i], i == plan.size() - 1);
    plan.delete();
  endtask

  function automatic raster_req_t mk_req(logic [rre_pkg::KIND_W-1:0] k, int f, int x, int y,
                                         int w, int h, int ch, int row, int col);
    raster_req_t it;
    it.kind        = k;
    it.rect_filled = f[0];
    it.rect_x      = x[rre_pkg::COORD_W-1:0];
    it.rect_y      = y[rre_pkg::COORD_W-1:0];
    it.rect_w      = w[rre_pkg::COORD_W-1:0];
    it.rect_h      = h[rre_pkg::COORD_W-1:0];
    it.paint_char  = ch[rre_pkg::CHAR_W-1:0];
    it.read_row    = row[rre_pkg::CELL_W-1:0];
    it.read_col    = col[rre_pkg::CELL_W-1:0];
    return it;
  endfunction

  function automatic int frac_part();
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, ONE - 1));
  endfunction

  function automatic raster_req_t make_random_request(int cols, int rows);
    raster_req_t it;
    int sel;
    int xv, yv, wv, hv;
    it.kind        = rre_pkg::KIND_READ;
    it.rect_filled = 1'($urandom);
    it.rect_x      = rre_pkg::COORD_W'($urandom);
    it.rect_y      = rre_pkg::COORD_W'($urandom);
    it.rect_w      = rre_pkg::COORD_W'($urandom);
    it.rect_h      = rre_pkg::COORD_W'($urandom);
    it.paint_char  = rre_pkg::CHAR_W'($urandom);
    it.read_row    = rre_pkg::CELL_W'($urandom);
    it.read_col    = rre_pkg::CELL_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      it.kind = rre_pkg::KIND_CLEAR;
    end else if (sel < 8) begin
      it.kind = KIND_UNUSED;
    end else if (sel < 48) begin
      if ($urandom_range(0, 6) != 0) begin
        it.read_row = rre_pkg::CELL_W'($urandom_range(0, rows - 1));
        it.read_col = rre_pkg::CELL_W'($urandom_range(0, cols - 1));
      end
    end else begin
      it.kind = rre_pkg::KIND_DRAW;
      // mostly rectangles near the canvas; the rest keeps raw field noise
      if ($urandom_range(0, 7) != 0) begin
        xv = (int'($urandom_range(0, cols + 3)) - 2) * ONE + frac_part();
        yv = (int'($urandom_range(0, rows + 3)) - 2) * ONE + frac_part();
        wv = int'($urandom_range(0, cols + 1)) * ONE + frac_part();
        hv = int'($urandom_range(0, rows + 1)) * ONE + frac_part();
        if (wv == 0) wv = ONE;
        if (hv == 0) hv = ONE;
        it.rect_x = xv[rre_pkg::COORD_W-1:0];
        it.rect_y = yv[rre_pkg::COORD_W-1:0];
        it.rect_w = wv[rre_pkg::COORD_W-1:0];
        it.rect_h = hv[rre_pkg::COORD_W-1:0];
        if ($urandom_range(0, 9) == 0)
          it.paint_char = ($urandom_range(0, 1) == 0) ? 8'd0 : rre_pkg::NEWLINE_CHAR;
        else
          it.paint_char = rre_pkg::CHAR_W'($urandom_range(1, 255));
      end
    end
    return it;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++)
      plan.push_back(make_random_request(sb.cols_in_use(), sb.rows_in_use()));
    flush_plan();
  endtask

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int xv, yv, wv, hv, top_row, left_col;
    sb = new();
    rst                 <= 1'b1;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= rre_pkg::REG_CANVAS_WIDTH;
    cfg_bus.data        <= '0;
    req_bus.valid       <= 1'b0;
    req_bus.kind        <= rre_pkg::KIND_CLEAR;
    req_bus.rect_filled <= 1'b0;
    req_bus.rect_x      <= '0;
    req_bus.rect_y      <= '0;
    req_bus.rect_w      <= '0;
    req_bus.rect_h      <= '0;
    req_bus.paint_char  <= '0;
    req_bus.read_row    <= '0;
    req_bus.read_col    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: single cell
    plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_req(KIND_UNUSED, 1, 0, 0, ONE, ONE, 65, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 1));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 0, 0, 0, ONE / 2, ONE / 2, 120, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    flush_plan();

    set_canvas(9, 7, 0);
    plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 0, ONE, ONE, 5 * ONE, 4 * ONE, 35, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1, 1));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 3, 3));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 5, 6));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, 5 * ONE / 2, -3 * ONE / 4, 13 * ONE / 4,
                          2 * ONE, 42, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1, 3));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 0, -ONE / 2, ONE / 4, 8 * ONE + 154,
                          6 * ONE + 26, 255, 0, 0));
    // rejected parameters
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, 0, 0, 0, ONE, 65, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, 0, 0, ONE, -524288, 65, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, 0, 0, ONE, ONE, 0, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, 0, 0, ONE, ONE, rre_pkg::NEWLINE_CHAR,
                          0, 0));
    // coordinate extremes; far-away outline covers the canvas but paints nothing
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 0, -524288, 524287, 524287, 524287, 66,
                          0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, -1000 * ONE, -1000 * ONE, 524287, 524287,
                          67, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 0, -1000 * ONE, -1000 * ONE, 524287, 524287,
                          68, 0, 0));
    plan.push_back(mk_req(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 511, 511));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 511));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 6, 8));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 3, 4));
    random_phase(10);

    // oversized width saturates, one row
    set_canvas(1023, 1, 255);
    plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    random_phase(8);

    set_canvas(1, 1023, $urandom_range(0, 255));
    plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    random_phase(8);

    // zero sizes act as one
    set_canvas(0, 0, $urandom_range(1, 254));
    plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    random_phase(5);

    // full canvas: one clear, one outline, reads along its edges and elsewhere, a rejected draw and an unused kind
    set_canvas(rre_pkg::MAX_WIDTH_DEF, rre_pkg::MAX_HEIGHT_DEF, $urandom_range(0, 255));
    xv = $urandom_range(0, 100) * ONE + $urandom_range(0, ONE - 1);
    yv = $urandom_range(0, 100) * ONE + $urandom_range(0, ONE - 1);
    wv = $urandom_range(200, 400) * ONE + $urandom_range(0, ONE - 1);
    hv = $urandom_range(200, 400) * ONE + $urandom_range(0, ONE - 1);
    top_row  = (yv + ONE - 1) / ONE;
    left_col = (xv + ONE - 1) / ONE;
    plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 0, xv, yv, wv, hv, $urandom_range(33, 126),
                          0, 0));
    for (int i = 0; i < 4; i++) begin
      plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, top_row,
                            left_col + $urandom_range(0, wv / ONE - 1)));
      plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0,
                            top_row + $urandom_range(0, hv / ONE - 1), left_col));
      plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, $urandom_range(0, 511),
                            $urandom_range(0, 511)));
    end
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, top_row + 1, left_col + 1));
    plan.push_back(mk_req(rre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 511, 511));
    plan.push_back(mk_req(rre_pkg::KIND_DRAW, 1, xv, yv, wv, hv, rre_pkg::NEWLINE_CHAR,
                          0, 0));
    plan.push_back(mk_req(KIND_UNUSED, 1, xv, yv, wv, hv, 90, 0, 0));
    flush_plan();

    for (int p = 0; p < 3; p++) begin
      set_canvas($urandom_range(2, 24), $urandom_range(2, 16), $urandom_range(0, 255));
      plan.push_back(mk_req(rre_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      random_phase(9);
    end

    drain_replies();
    repeat (40) @(posedge clk);
    sb.report_leftovers();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* rectangle_raster_engine.f */
rtl/core/rre_pkg.sv
rtl/core/rre_if.sv
rtl/core/rre_canvas.sv
rtl/core/rectangle_raster_engine.sv
bench/tb_rectangle_raster_engine.sv
